/* sv/prs_pkg.sv */
// ----------------------------------------------------------------------------
// prs_pkg: shared types and constants of the pairwise rigidity score block
// Fixed-point widths, register indexes, queue sizing and reciprocal table.
// ----------------------------------------------------------------------------
package prs_pkg;

    // coordinate format
    localparam int COORD_FRAC_BITS = 16;
    localparam int COORD_W         = 32;
    localparam int MAG_W           = 32;
    localparam int SQ_W            = 64;
    localparam int RAD_W           = 66;
    localparam int ROOT_W          = 34;
    localparam int TRIAL_W         = 68;

    // distance difference and exponent argument
    localparam int DW       = COORD_FRAC_BITS + 10;
    localparam int D2W      = 2 * DW;
    localparam int D2_LO_W  = 32;
    localparam int D2_HI_W  = D2W - D2_LO_W;
    localparam int KCOEF_W  = 32;
    localparam int FULL_W   = D2W + KCOEF_W;
    localparam int X_SH     = 2 * COORD_FRAC_BITS - 16;
    localparam int X_INT_W  = FULL_W - 32 - X_SH;
    localparam int T_W      = 29;
    localparam int V_W      = 30;
    localparam int EXP_W    = 32;
    localparam int SCORE_W  = 17;
    localparam int THR_W    = 17;

    localparam logic [X_INT_W-1:0] X_LIMIT_INT = X_INT_W'(12);
    localparam logic [EXP_W-1:0]   EXP_ONE     = 32'h8000_0000;

    // exponent pipeline shape
    localparam int TAYLOR_TERMS = 8;
    localparam int SQUARINGS    = 6;

    // queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COEFF    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 8'd1;
    localparam logic [KCOEF_W-1:0]   KERNEL_RESET        = 32'd65536;
    localparam logic [THR_W-1:0]     THRESHOLD_RESET     = 17'd45875;

    // floor(2^32 / n) for the Taylor term divisors
    localparam logic [32:0] RECIP [1:TAYLOR_TERMS] = '{
        33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
        33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912
    };

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } prs_point_t;

    typedef struct packed {
        logic [RAD_W-1:0] src_rad;
        logic [RAD_W-1:0] tgt_rad;
    } prs_rad_t;

    typedef struct packed {
        logic     valid;
        prs_rad_t rad;
    } prs_item_t;

    typedef struct packed {
        logic [KCOEF_W-1:0] kernel_coeff;
        logic [THR_W-1:0]   score_threshold;
    } prs_cfg_t;

    // magnitude of the difference of two coordinates
    function automatic logic [MAG_W-1:0] abs_diff(input coord_t a, input coord_t b);
        logic signed [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[COORD_W] ? MAG_W'(-d) : MAG_W'(d);
    endfunction

endpackage

/* sv/prs_front.sv */
// ----------------------------------------------------------------------------
// prs_front: accept stage
// Takes a transaction, forms squared distances of the two point pairs over
// three stages and pushes the radicands into the queue.
// ----------------------------------------------------------------------------
module prs_front
    import prs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  prs_point_t        src_a,
    input  prs_point_t        tgt_a,
    input  prs_point_t        src_b,
    input  prs_point_t        tgt_b,
    input  logic [QCNT_W-1:0] q_count,
    output prs_item_t         push_item
);

    logic              s1_v_reg;
    logic              s2_v_reg;
    logic              s3_v_reg;
    logic [MAG_W-1:0]  mag_reg [0:5];
    logic [SQ_W-1:0]   sq_reg  [0:5];
    prs_rad_t          rad_reg;
    logic [QCNT_W+1:0] occupancy;
    logic              accept;

    // count every item already headed for the queue; the back pops one
    // entry every cycle it is not empty, so a full pipeline plus one queued entry still fits
    assign occupancy = (QCNT_W+2)'(q_count) + (QCNT_W+2)'(s1_v_reg)
                     + (QCNT_W+2)'(s2_v_reg) + (QCNT_W+2)'(s3_v_reg);
    assign busy   = (occupancy > (QCNT_W+2)'(QDEPTH));
    assign accept = start && !busy;

    // advance valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    // coordinate differences, squares and sums
    always_ff @(posedge clk)
    begin
        mag_reg[0] <= abs_diff(src_a.x, src_b.x);
        mag_reg[1] <= abs_diff(src_a.y, src_b.y);
        mag_reg[2] <= abs_diff(src_a.z, src_b.z);
        mag_reg[3] <= abs_diff(tgt_a.x, tgt_b.x);
        mag_reg[4] <= abs_diff(tgt_a.y, tgt_b.y);
        mag_reg[5] <= abs_diff(tgt_a.z, tgt_b.z);
        for (int i = 0; i < 6; i++)
        begin
            sq_reg[i] <= mag_reg[i] * mag_reg[i];
        end
        rad_reg.src_rad <= RAD_W'(sq_reg[0]) + RAD_W'(sq_reg[1]) + RAD_W'(sq_reg[2]);
        rad_reg.tgt_rad <= RAD_W'(sq_reg[3]) + RAD_W'(sq_reg[4]) + RAD_W'(sq_reg[5]);
    end

    assign push_item.valid = s3_v_reg;
    assign push_item.rad   = rad_reg;

endmodule

/* sv/prs_queue.sv */
// ----------------------------------------------------------------------------
// prs_queue: short FIFO between front and back
// Holds radicand pairs so front and back advance independently.
// ----------------------------------------------------------------------------
module prs_queue
    import prs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  prs_item_t         push_item,
    input  logic              pop,
    output prs_item_t         head,
    output logic [QCNT_W-1:0] count
);

    prs_rad_t          mem_reg [0:QDEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign count_next = count_reg + QCNT_W'(push_item.valid) - QCNT_W'(pop);

    // advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_item.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // store entry
    always_ff @(posedge clk)
    begin
        if (push_item.valid)
        begin
            mem_reg[wr_ptr_reg] <= push_item.rad;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.rad   = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

/* sv/prs_isqrt.sv */
// ----------------------------------------------------------------------------
// prs_isqrt: pipelined integer square root
// Restoring square root, one root bit per stage, most significant first.
// ----------------------------------------------------------------------------
module prs_isqrt
    import prs_pkg::*;
(
    input  logic              clk,
    input  logic [RAD_W-1:0]  rad,
    output logic [ROOT_W-1:0] root
);

    logic [ROOT_W-1:0] root_reg [0:ROOT_W-1];
    logic [RAD_W-1:0]  rem_reg  [0:ROOT_W-1];

    genvar i;
    generate
        for (i = 0; i < ROOT_W; i++)
        begin : g_stage
            localparam int B = ROOT_W - 1 - i;
            logic [ROOT_W-1:0]  root_in;
            logic [RAD_W-1:0]   rem_in;
            logic [TRIAL_W-1:0] trial;

            if (i == 0)
            begin : g_first
                assign root_in = '0;
                assign rem_in  = rad;
            end
            else
            begin : g_next
                assign root_in = root_reg[i-1];
                assign rem_in  = rem_reg[i-1];
            end

            // (r + 2^b)^2 - r^2
            assign trial = (TRIAL_W'(root_in) << (B + 1)) + (TRIAL_W'(1) << (2 * B));

            // take the bit when the remainder covers it
            always_ff @(posedge clk)
            begin
                if (trial <= TRIAL_W'(rem_in))
                begin
                    rem_reg[i]  <= rem_in - RAD_W'(trial);
                    root_reg[i] <= root_in | (ROOT_W'(1) << B);
                end
                else
                begin
                    rem_reg[i]  <= rem_in;
                    root_reg[i] <= root_in;
                end
            end
        end
    endgenerate

    assign root = root_reg[ROOT_W-1];

endmodule

/* sv/prs_back.sv */
// ----------------------------------------------------------------------------
// prs_back: scoring pipeline
// Square roots, distance difference, exponent argument, Taylor series of
// exp, repeated squaring, rounding and threshold test. Never stalls.
// ----------------------------------------------------------------------------
module prs_back
    import prs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  prs_item_t          head,
    output logic               pop,
    input  prs_cfg_t           cfg,
    output logic               done,
    output logic [SCORE_W-1:0] score,
    output logic               compatible
);

    localparam int LAT     = ROOT_W + 4 + 3 * TAYLOR_TERMS + SQUARINGS;
    localparam int INR_LEN = 3 * TAYLOR_TERMS + SQUARINGS + 1;

    logic [LAT-1:0]     valid_reg;
    logic [INR_LEN-1:0] inr_reg;
    logic [ROOT_W-1:0]  ds;
    logic [ROOT_W-1:0]  dt;

    logic [DW-1:0]      d_reg;
    logic               big_reg;
    logic [D2W-1:0]     d2_reg;
    logic               big2_reg;
    logic [63:0]        pp_lo_reg;
    logic [D2_HI_W+KCOEF_W-1:0] pp_hi_reg;
    logic               kzero_reg;
    logic               big3_reg;
    logic [FULL_W-1:0]  full;
    logic [T_W-1:0]     t_x_reg;

    logic [EXP_W-1:0]   term_c [0:TAYLOR_TERMS];
    logic [EXP_W-1:0]   sum_c  [0:TAYLOR_TERMS];
    logic [T_W-1:0]     t_c    [0:TAYLOR_TERMS];
    logic [EXP_W-1:0]   e_reg  [1:SQUARINGS];
    logic [EXP_W-1:0]   e_in   [0:SQUARINGS];

    logic [EXP_W:0]     rounded;
    logic [SCORE_W-1:0] score_raw;
    logic               ok;
    logic               done_reg;
    logic [SCORE_W-1:0] score_reg;
    logic               compat_reg;

    assign pop = head.valid;

    prs_isqrt u_isqrt_src
    (
        .clk  (clk),
        .rad  (head.rad.src_rad),
        .root (ds)
    );

    prs_isqrt u_isqrt_tgt
    (
        .clk  (clk),
        .rad  (head.rad.tgt_rad),
        .root (dt)
    );

    // advance valid flags and the done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[LAT-2:0], head.valid};
            done_reg  <= valid_reg[LAT-1];
        end
    end

    // distance difference, square and kernel product
    always_ff @(posedge clk)
    begin
        if (ds > dt)
        begin
            d_reg   <= DW'(ds - dt);
            big_reg <= ((ds - dt) >> DW) != '0;
        end
        else
        begin
            d_reg   <= DW'(dt - ds);
            big_reg <= ((dt - ds) >> DW) != '0;
        end
        d2_reg    <= d_reg * d_reg;
        big2_reg  <= big_reg;
        pp_lo_reg <= d2_reg[D2_LO_W-1:0] * cfg.kernel_coeff;
        pp_hi_reg <= d2_reg[D2W-1:D2_LO_W] * cfg.kernel_coeff;
        kzero_reg <= (cfg.kernel_coeff == '0);
        big3_reg  <= big2_reg;
        t_x_reg   <= full[X_SH+7 +: T_W];
    end

    assign full = (FULL_W'(pp_hi_reg) << D2_LO_W) + FULL_W'(pp_lo_reg);

    // in-range flag of the exponent, then delay to the output
    always_ff @(posedge clk)
    begin
        inr_reg[0] <= kzero_reg || (!big3_reg && (full[FULL_W-1:32+X_SH] < X_LIMIT_INT));
        inr_reg[INR_LEN-1:1] <= inr_reg[INR_LEN-2:0];
    end

    assign term_c[0] = EXP_ONE;
    assign sum_c[0]  = EXP_ONE;
    assign t_c[0]    = t_x_reg;

    // Taylor series of exp(-t): multiply, reciprocal, correct and accumulate
    genvar n;
    generate
        for (n = 1; n <= TAYLOR_TERMS; n++)
        begin : g_term
            logic [V_W-1:0]   a_v_reg;
            logic [T_W-1:0]   a_t_reg;
            logic [EXP_W-1:0] a_sum_reg;
            logic [V_W-1:0]   b_v_reg;
            logic [V_W-1:0]   b_q0_reg;
            logic [T_W-1:0]   b_t_reg;
            logic [EXP_W-1:0] b_sum_reg;
            logic [EXP_W-1:0] c_term_reg;
            logic [EXP_W-1:0] c_sum_reg;
            logic [T_W-1:0]   c_t_reg;
            logic [T_W+EXP_W-1:0] prod;
            logic [V_W+32:0]  qm;
            logic [V_W-1:0]   r;
            logic [V_W-1:0]   q;

            assign prod = term_c[n-1] * t_c[n-1];
            assign qm   = a_v_reg * RECIP[n];
            assign r    = b_v_reg - b_q0_reg * V_W'(n);
            assign q    = (r >= V_W'(n)) ? b_q0_reg + 1'b1 : b_q0_reg;

            always_ff @(posedge clk)
            begin
                a_v_reg    <= prod[31 +: V_W];
                a_t_reg    <= t_c[n-1];
                a_sum_reg  <= sum_c[n-1];
                b_v_reg    <= a_v_reg;
                b_q0_reg   <= qm[32 +: V_W];
                b_t_reg    <= a_t_reg;
                b_sum_reg  <= a_sum_reg;
                c_term_reg <= EXP_W'(q);
                c_t_reg    <= b_t_reg;
                if (n % 2 == 1)
                begin
                    c_sum_reg <= b_sum_reg - EXP_W'(q);
                end
                else
                begin
                    c_sum_reg <= b_sum_reg + EXP_W'(q);
                end
            end

            assign term_c[n] = c_term_reg;
            assign sum_c[n]  = c_sum_reg;
            assign t_c[n]    = c_t_reg;
        end
    endgenerate

    // square back up to exp(-64t)
    assign e_in[0] = sum_c[TAYLOR_TERMS];

    genvar j;
    generate
        for (j = 1; j <= SQUARINGS; j++)
        begin : g_square
            logic [2*EXP_W-1:0] sqp;

            assign sqp = e_in[j-1] * e_in[j-1];

            always_ff @(posedge clk)
            begin
                e_reg[j] <= sqp[31 +: EXP_W];
            end

            assign e_in[j] = e_reg[j];
        end
    endgenerate

    // round to Q1.16 and test against the threshold
    assign rounded   = (EXP_W+1)'(e_in[SQUARINGS]) + (EXP_W+1)'(32'h4000);
    assign score_raw = inr_reg[INR_LEN-1] ? rounded[15 +: SCORE_W] : '0;
    assign ok        = (score_raw >= cfg.score_threshold);

    always_ff @(posedge clk)
    begin
        score_reg  <= ok ? score_raw : '0;
        compat_reg <= ok;
    end

    assign done       = done_reg;
    assign score      = score_reg;
    assign compatible = compat_reg;

endmodule

/* sv/pairwise_rigidity_score.sv */
// ----------------------------------------------------------------------------
// pairwise_rigidity_score: Gaussian compatibility score of two correspondences
// Scores how well the source and target distances of a pair agree.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the twelve coordinates (signed Q16.16) with start high; the
//   transaction is taken at a clock edge where start is high and busy low.
//   One transaction per cycle is sustained; busy only rises if the queue
//   between the accept stage and the scoring pipeline could overflow.
//   Each transaction yields one result on score/compatible, marked by a
//   one-cycle done strobe. Between the accepting edge and done lie the
//   three accept stages, the queue, the two 34-stage square root pipelines,
//   four stages of distance and exponent argument, the eight three-stage
//   Taylor terms, six squarings and the output register.
//   Results come in acceptance order and cannot be held off by the receiver.
//   Registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data. The
//   user must write only while no transaction is in flight; the block does
//   not enforce this. Index 0 kernel_coeff, index 1 score_threshold; other
//   indexes are ignored. cfg_ready is always high. Reset empties the
//   pipeline and sets kernel_coeff to 1.0 and score_threshold to 0.7.
// ----------------------------------------------------------------------------
module pairwise_rigidity_score
    import prs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [31:0]    src_a_x,
    input  logic signed [31:0]    src_a_y,
    input  logic signed [31:0]    src_a_z,
    input  logic signed [31:0]    tgt_a_x,
    input  logic signed [31:0]    tgt_a_y,
    input  logic signed [31:0]    tgt_a_z,
    input  logic signed [31:0]    src_b_x,
    input  logic signed [31:0]    src_b_y,
    input  logic signed [31:0]    src_b_z,
    input  logic signed [31:0]    tgt_b_x,
    input  logic signed [31:0]    tgt_b_y,
    input  logic signed [31:0]    tgt_b_z,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic [SCORE_W-1:0]    score,
    output logic                  compatible
);

    logic [KCOEF_W-1:0] kernel_coeff_reg;
    logic [THR_W-1:0]   score_threshold_reg;
    prs_cfg_t           cfg;
    prs_point_t         src_a;
    prs_point_t         tgt_a;
    prs_point_t         src_b;
    prs_point_t         tgt_b;
    prs_item_t          push_item;
    prs_item_t          head;
    logic               pop;
    logic [QCNT_W-1:0]  q_count;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_coeff_reg    <= KERNEL_RESET;
            score_threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KERNEL_COEFF:    kernel_coeff_reg    <= cfg_data;
                REG_SCORE_THRESHOLD: score_threshold_reg <= cfg_data[THR_W-1:0];
                default:             ;
            endcase
        end
    end

    assign cfg.kernel_coeff    = kernel_coeff_reg;
    assign cfg.score_threshold = score_threshold_reg;

    assign src_a = '{x: src_a_x, y: src_a_y, z: src_a_z};
    assign tgt_a = '{x: tgt_a_x, y: tgt_a_y, z: tgt_a_z};
    assign src_b = '{x: src_b_x, y: src_b_y, z: src_b_z};
    assign tgt_b = '{x: tgt_b_x, y: tgt_b_y, z: tgt_b_z};

    prs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .src_a     (src_a),
        .tgt_a     (tgt_a),
        .src_b     (src_b),
        .tgt_b     (tgt_b),
        .q_count   (q_count),
        .push_item (push_item)
    );

    prs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .count     (q_count)
    );

    prs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .cfg        (cfg),
        .done       (done),
        .score      (score),
        .compatible (compatible)
    );

endmodule
